/* rtl/bre_pkg.sv */
package bre_pkg;

    localparam int CMD_W   = 4;
    localparam int FIELD_W = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET      = 4'd0,
        CMD_SET      = 4'd1,
        CMD_CLR      = 4'd2,
        CMD_TOG      = 4'd3,
        CMD_WRITE    = 4'd4,
        CMD_SETRANGE = 4'd5,
        CMD_CLRRANGE = 4'd6,
        CMD_TOGRANGE = 4'd7,
        CMD_SETALL   = 4'd8,
        CMD_CLRALL   = 4'd9,
        CMD_TOGALL   = 4'd10,
        CMD_RESIZE   = 4'd11,
        CMD_CLEAR    = 4'd12
    } cmd_code_t;

    typedef enum logic [1:0] {
        OP_GET,
        OP_SET,
        OP_CLR,
        OP_TOG
    } word_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WALK,
        ST_RESP
    } state_t;

endpackage

/* rtl/bre_cmd_if.sv */
interface bre_cmd_if;

    logic                          valid;
    logic                          ready;
    logic [bre_pkg::CMD_W-1:0]     command;
    logic [bre_pkg::FIELD_W-1:0]   bit_index;
    logic [bre_pkg::FIELD_W-1:0]   bit_count;
    logic                          bit_value;

    modport source (
        output valid,
        output command,
        output bit_index,
        output bit_count,
        output bit_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  bit_index,
        input  bit_count,
        input  bit_value,
        output ready
    );

endinterface

/* rtl/bre_rsp_if.sv */
interface bre_rsp_if;

    logic                          valid;
    logic                          ready;
    logic                          previous_bit;
    logic [bre_pkg::FIELD_W-1:0]   bits_touched;
    logic [bre_pkg::FIELD_W-1:0]   current_size;

    modport source (
        output valid,
        output previous_bit,
        output bits_touched,
        output current_size,
        input  ready
    );

    modport sink (
        input  valid,
        input  previous_bit,
        input  bits_touched,
        input  current_size,
        output ready
    );

endinterface

/* rtl/bre_word_unit.sv */
module bre_word_unit #(
    parameter int WORD_BITS = 64
) (
    input  bre_pkg::word_op_t                  op,
    input  logic [$clog2(WORD_BITS)-1:0]       lo,
    input  logic [$clog2(WORD_BITS)-1:0]       hi,
    input  logic [WORD_BITS-1:0]               word_in,
    output logic [WORD_BITS-1:0]               word_out
);

    logic [WORD_BITS-1:0] mask;

    assign mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (~hi));

    always_comb
    begin
        case (op)
            bre_pkg::OP_SET: word_out = word_in | mask;
            bre_pkg::OP_CLR: word_out = word_in & ~mask;
            bre_pkg::OP_TOG: word_out = word_in ^ mask;
            default:         word_out = word_in;
        endcase
    end

endmodule

/* rtl/bitmap_range_engine.sv */
// Bit vector of MAX_BITS bits held as WORD_BITS-bit words, with a logical size.
// cmd (sink): one beat carries command, bit_index, bit_count and bit_value.
// rsp (source): one beat per command with previous_bit, bits_touched and
// current_size (size after the command).
// A command is taken only while the engine is idle. After acceptance it
// decodes and clips the command in ST_LOAD, walks the words it covers in
// ST_WALK, then hands the result to the output register in ST_RESP.
// Single-bit commands in range and a resize that ends inside a word walk one
// word; range and whole-vector commands walk every word they cover; clear,
// commands out of range or of zero length, and unused codes walk none.
// The word memory has one read and one write port; a read of the next word
// overlaps the write of the current one.
// Reset empties the vector at once (per-word valid flags) and sets size 0;
// no sweep is needed. A stalled rsp holds its beat in the output register;
// the engine finishes the next command and waits until that register frees.
module bitmap_range_engine #(
    parameter int MAX_BITS  = 4096,
    parameter int WORD_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    bre_cmd_if.sink        cmd,
    bre_rsp_if.source      rsp
);

    localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int PW        = $clog2(MAX_BITS + 1);
    localparam int FW        = bre_pkg::FIELD_W;
    localparam int SW        = (PW > FW) ? PW : FW;

    bre_pkg::state_t                 state_reg, state_next;
    logic [bre_pkg::CMD_W-1:0]       cmd_reg;
    logic [SW-1:0]                   idx_reg, cnt_reg;
    logic                            val_reg;
    logic [SW-1:0]                   size_reg, size_next;
    bre_pkg::word_op_t               op_reg, op_next;
    logic [AW-1:0]                   first_reg, first_next;
    logic [AW-1:0]                   last_reg, last_next;
    logic [AW-1:0]                   cur_reg, cur_next;
    logic [OW-1:0]                   lo_off_reg, lo_off_next;
    logic [OW-1:0]                   hi_off_reg, hi_off_next;
    logic                            is_bit_reg, is_bit_next;
    logic                            prev_reg, prev_next;
    logic [SW-1:0]                   touched_reg, touched_next;
    logic [NUM_WORDS-1:0]            valid_reg, valid_next;
    logic                            walk_go;

    logic [WORD_BITS-1:0]            mem [NUM_WORDS];
    logic [WORD_BITS-1:0]            rd_data_reg;
    logic                            rd_valid_reg;
    logic [AW-1:0]                   rd_addr;
    logic                            mem_we;
    logic [WORD_BITS-1:0]            base_word, new_word;
    logic [OW-1:0]                   lo_eff, hi_eff;

    logic                            out_valid_reg, out_valid_next;
    logic                            out_prev_reg;
    logic [FW-1:0]                   out_touched_reg, out_size_reg;
    logic                            out_load;

    logic                            in_range;
    logic [SW:0]                     sum_m1;
    logic [SW-1:0]                   size_m1, avail, endpos, new_size;
    logic                            clipped;
    logic [SW-1:0]                   idx_word, end_word, size_word, new_word_idx;

    assign cmd.ready = (state_reg == bre_pkg::ST_IDLE);

    assign in_range     = idx_reg < size_reg;
    assign sum_m1       = {1'b0, idx_reg} + {1'b0, cnt_reg} - {{SW{1'b0}}, 1'b1};
    assign size_m1      = size_reg - {{(SW-1){1'b0}}, 1'b1};
    assign avail        = size_reg - idx_reg;
    assign clipped      = sum_m1 > {1'b0, size_m1};
    assign endpos       = clipped ? size_m1 : sum_m1[SW-1:0];
    assign new_size     = (cnt_reg > SW'(MAX_BITS)) ? SW'(MAX_BITS) : cnt_reg;
    assign idx_word     = idx_reg >> OW;
    assign end_word     = endpos >> OW;
    assign size_word    = size_m1 >> OW;
    assign new_word_idx = new_size >> OW;

    assign base_word = rd_valid_reg ? rd_data_reg : '0;
    assign lo_eff    = (cur_reg == first_reg) ? lo_off_reg : '0;
    assign hi_eff    = (cur_reg == last_reg) ? hi_off_reg : '1;
    assign mem_we    = (state_reg == bre_pkg::ST_WALK) && (op_reg != bre_pkg::OP_GET);
    assign rd_addr   = (state_reg == bre_pkg::ST_LOAD) ? first_next
                                                       : cur_reg + {{(AW-1){1'b0}}, 1'b1};
    assign out_load  = (state_reg == bre_pkg::ST_RESP) && (!out_valid_reg || rsp.ready);

    bre_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .op       (op_reg),
        .lo       (lo_eff),
        .hi       (hi_eff),
        .word_in  (base_word),
        .word_out (new_word)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bre_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = bre_pkg::ST_LOAD;
                end
            end
            bre_pkg::ST_LOAD:
            begin
                state_next = walk_go ? bre_pkg::ST_WALK : bre_pkg::ST_RESP;
            end
            bre_pkg::ST_WALK:
            begin
                if (cur_reg == last_reg)
                begin
                    state_next = bre_pkg::ST_RESP;
                end
            end
            bre_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = bre_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bre_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        walk_go      = 1'b0;
        size_next    = size_reg;
        op_next      = op_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        cur_next     = cur_reg;
        lo_off_next  = lo_off_reg;
        hi_off_next  = hi_off_reg;
        is_bit_next  = is_bit_reg;
        prev_next    = prev_reg;
        touched_next = touched_reg;
        valid_next   = valid_reg;
        case (state_reg)
            bre_pkg::ST_LOAD:
            begin
                is_bit_next  = 1'b0;
                prev_next    = 1'b0;
                touched_next = '0;
                case (bre_pkg::cmd_code_t'(cmd_reg))
                    bre_pkg::CMD_GET, bre_pkg::CMD_SET, bre_pkg::CMD_CLR,
                    bre_pkg::CMD_TOG, bre_pkg::CMD_WRITE:
                    begin
                        is_bit_next = 1'b1;
                        walk_go     = in_range;
                        first_next  = idx_word[AW-1:0];
                        last_next   = idx_word[AW-1:0];
                        lo_off_next = idx_reg[OW-1:0];
                        hi_off_next = idx_reg[OW-1:0];
                        case (bre_pkg::cmd_code_t'(cmd_reg))
                            bre_pkg::CMD_SET:   op_next = bre_pkg::OP_SET;
                            bre_pkg::CMD_CLR:   op_next = bre_pkg::OP_CLR;
                            bre_pkg::CMD_TOG:   op_next = bre_pkg::OP_TOG;
                            bre_pkg::CMD_WRITE: op_next = val_reg ? bre_pkg::OP_SET
                                                                  : bre_pkg::OP_CLR;
                            default:            op_next = bre_pkg::OP_GET;
                        endcase
                    end
                    bre_pkg::CMD_SETRANGE, bre_pkg::CMD_CLRRANGE, bre_pkg::CMD_TOGRANGE:
                    begin
                        if (in_range && (cnt_reg != '0))
                        begin
                            walk_go      = 1'b1;
                            touched_next = clipped ? avail : cnt_reg;
                        end
                        first_next  = idx_word[AW-1:0];
                        last_next   = end_word[AW-1:0];
                        lo_off_next = idx_reg[OW-1:0];
                        hi_off_next = endpos[OW-1:0];
                        case (bre_pkg::cmd_code_t'(cmd_reg))
                            bre_pkg::CMD_SETRANGE: op_next = bre_pkg::OP_SET;
                            bre_pkg::CMD_CLRRANGE: op_next = bre_pkg::OP_CLR;
                            default:               op_next = bre_pkg::OP_TOG;
                        endcase
                    end
                    bre_pkg::CMD_SETALL, bre_pkg::CMD_CLRALL, bre_pkg::CMD_TOGALL:
                    begin
                        walk_go     = (size_reg != '0);
                        first_next  = '0;
                        last_next   = size_word[AW-1:0];
                        lo_off_next = '0;
                        hi_off_next = size_m1[OW-1:0];
                        case (bre_pkg::cmd_code_t'(cmd_reg))
                            bre_pkg::CMD_SETALL: op_next = bre_pkg::OP_SET;
                            bre_pkg::CMD_CLRALL: op_next = bre_pkg::OP_CLR;
                            default:             op_next = bre_pkg::OP_TOG;
                        endcase
                    end
                    bre_pkg::CMD_RESIZE:
                    begin
                        size_next = new_size;
                        for (int w = 0; w < NUM_WORDS; w++)
                        begin
                            valid_next[w] = valid_reg[w] && (SW'(w * WORD_BITS) < new_size);
                        end
                        walk_go     = (new_size[OW-1:0] != '0);
                        op_next     = bre_pkg::OP_CLR;
                        first_next  = new_word_idx[AW-1:0];
                        last_next   = new_word_idx[AW-1:0];
                        lo_off_next = new_size[OW-1:0];
                        hi_off_next = '1;
                    end
                    bre_pkg::CMD_CLEAR:
                    begin
                        size_next  = '0;
                        valid_next = '0;
                    end
                    default:
                    begin
                        walk_go = 1'b0;
                    end
                endcase
                cur_next = first_next;
            end
            bre_pkg::ST_WALK:
            begin
                if (is_bit_reg)
                begin
                    prev_next = base_word[lo_off_reg];
                end
                if (mem_we)
                begin
                    valid_next[cur_reg] = 1'b1;
                end
                cur_next = cur_reg + {{(AW-1){1'b0}}, 1'b1};
            end
            default:
            begin
                walk_go = 1'b0;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && !rsp.ready) || out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bre_pkg::ST_IDLE;
            size_reg      <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            op_reg        <= bre_pkg::OP_GET;
            first_reg     <= '0;
            last_reg      <= '0;
            cur_reg       <= '0;
            is_bit_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= valid_reg[rd_addr];
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
            is_bit_reg    <= is_bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd.command;
            idx_reg <= SW'(cmd.bit_index);
            cnt_reg <= SW'(cmd.bit_count);
            val_reg <= cmd.bit_value;
        end
        lo_off_reg  <= lo_off_next;
        hi_off_reg  <= hi_off_next;
        prev_reg    <= prev_next;
        touched_reg <= touched_next;
        if (out_load)
        begin
            out_prev_reg    <= is_bit_reg & prev_reg;
            out_touched_reg <= touched_reg[FW-1:0];
            out_size_reg    <= size_reg[FW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_reg] <= new_word;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.previous_bit = out_prev_reg;
    assign rsp.bits_touched = out_touched_reg;
    assign rsp.current_size = out_size_reg;

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= SW'(MAX_BITS))
        else $error("logical size above capacity");

    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> state_reg == bre_pkg::ST_LOAD)
        else $error("accepted command not decoded");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bre_pkg::ST_WALK |-> cur_reg >= first_reg && cur_reg <= last_reg)
        else $error("word walk out of bounds");

    a_write_below_size: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((SW'(cur_reg) << OW) < size_reg))
        else $error("word written above logical size");

    a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> state_reg == bre_pkg::ST_IDLE && out_valid_reg)
        else $error("result not presented");

endmodule

/* tb/tb_bitmap_range_engine.sv */
`timescale 1ns / 1ps

module tb_bitmap_range_engine;

    localparam int CMD_W         = bre_pkg::CMD_W;
    localparam int FIELD_W       = bre_pkg::FIELD_W;
    localparam int MAX_BITS      = 4096;
    localparam int WORD_BITS     = 64;
    localparam int NUM_WORDS     = MAX_BITS / WORD_BITS;
    localparam int FIELD_MAX     = (1 << FIELD_W) - 1;
    localparam int CMD_LAST_CODE = (1 << CMD_W) - 1;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = NUM_WORDS + 16;

    typedef struct packed {
        logic               previous_bit;
        logic [FIELD_W-1:0] bits_touched;
        logic [FIELD_W-1:0] current_size;
    } bre_result_t;

    class bit_vector_tracker;
        logic [WORD_BITS-1:0] mirror_words [NUM_WORDS];
        int                   mirror_size;
        bre_result_t          expected_rsps [$];
        int                   mismatches;

        function new();
            foreach (mirror_words[w])
                mirror_words[w] = '0;
            mirror_size = 0;
            mismatches  = 0;
        endfunction

        function automatic logic read_bit(int pos);
            return mirror_words[pos / WORD_BITS][pos % WORD_BITS];
        endfunction

        function automatic void write_bit(int pos, logic val);
            mirror_words[pos / WORD_BITS][pos % WORD_BITS] = val;
        endfunction

        function automatic void note_command(logic [CMD_W-1:0] code, logic [FIELD_W-1:0] idx,
                                             logic [FIELD_W-1:0] cnt, logic val);
            bre_result_t exp_rsp;
            int          first;
            int          span;
            exp_rsp = '0;
            first   = idx;
            span    = cnt;
            case (code)
                bre_pkg::CMD_GET, bre_pkg::CMD_SET, bre_pkg::CMD_CLR, bre_pkg::CMD_TOG,
                bre_pkg::CMD_WRITE:
                begin
                    if (first < mirror_size)
                    begin
                        exp_rsp.previous_bit = read_bit(first);
                        case (code)
                            bre_pkg::CMD_SET:   write_bit(first, 1'b1);
                            bre_pkg::CMD_CLR:   write_bit(first, 1'b0);
                            bre_pkg::CMD_TOG:   write_bit(first, ~exp_rsp.previous_bit);
                            bre_pkg::CMD_WRITE: write_bit(first, val);
                            default:   ;
                        endcase
                    end
                end
                bre_pkg::CMD_SETRANGE, bre_pkg::CMD_CLRRANGE, bre_pkg::CMD_TOGRANGE:
                begin
                    if (first < mirror_size)
                    begin
                        if (span > mirror_size - first)
                            span = mirror_size - first;
                        exp_rsp.bits_touched = FIELD_W'(span);
                        for (int p = first; p < first + span; p++)
                        begin
                            if (code == bre_pkg::CMD_SETRANGE)
                                write_bit(p, 1'b1);
                            else if (code == bre_pkg::CMD_CLRRANGE)
                                write_bit(p, 1'b0);
                            else
                                write_bit(p, ~read_bit(p));
                        end
                    end
                end
                bre_pkg::CMD_SETALL:
                    for (int p = 0; p < mirror_size; p++)
                        write_bit(p, 1'b1);
                bre_pkg::CMD_CLRALL:
                    for (int p = 0; p < mirror_size; p++)
                        write_bit(p, 1'b0);
                bre_pkg::CMD_TOGALL:
                    for (int p = 0; p < mirror_size; p++)
                        write_bit(p, ~read_bit(p));
                bre_pkg::CMD_RESIZE:
                begin
                    if (span > MAX_BITS)
                        span = MAX_BITS;
                    for (int p = span; p < MAX_BITS; p++)
                        write_bit(p, 1'b0);
                    mirror_size = span;
                end
                bre_pkg::CMD_CLEAR:
                begin
                    foreach (mirror_words[w])
                        mirror_words[w] = '0;
                    mirror_size = 0;
                end
                default: ;
            endcase
            exp_rsp.current_size = FIELD_W'(mirror_size);
            expected_rsps.push_back(exp_rsp);
        endfunction

        task report(string what, int got, int want);
            mismatches++;
            $display("[%0t] mismatch %0d: %s got %0d expected %0d",
                     $time, mismatches, what, got, want);
        endtask

        task check_response(bre_result_t got);
            bre_result_t want;
            if (expected_rsps.size() == 0)
            begin
                report("unexpected beat, current_size", got.current_size, -1);
                return;
            end
            want = expected_rsps.pop_front();
            if (got.previous_bit !== want.previous_bit)
                report("previous_bit", got.previous_bit, want.previous_bit);
            if (got.bits_touched !== want.bits_touched)
                report("bits_touched", got.bits_touched, want.bits_touched);
            if (got.current_size !== want.current_size)
                report("current_size", got.current_size, want.current_size);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    int cmd_gap_pct;
    int rsp_stall_pct;

    bit_vector_tracker tracker;

    bre_cmd_if cmd_if ();
    bre_rsp_if rsp_if ();

    bitmap_range_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_response('{rsp_if.previous_bit, rsp_if.bits_touched,
                                     rsp_if.current_size});
        rsp_if.ready <= rst_n && ($urandom_range(0, 99) >= rsp_stall_pct);
    end

    task automatic drive_cmd(input logic [CMD_W-1:0] code, input int idx, input int cnt,
                             input logic val);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < cmd_gap_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.command   <= code;
        cmd_if.bit_index <= FIELD_W'(idx);
        cmd_if.bit_count <= FIELD_W'(cnt);
        cmd_if.bit_value <= val;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        tracker.note_command(code, FIELD_W'(idx), FIELD_W'(cnt), val);
    endtask

    task automatic hold_until_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_index(int sz);
        int r;
        r = $urandom_range(0, 99);
        if (sz > 0 && r < 85)
            return $urandom_range(0, sz - 1);
        if (r < 92)
            return sz;
        return $urandom_range(0, FIELD_MAX);
    endfunction

    task automatic random_command();
        logic [CMD_W-1:0] code;
        int               pick;
        int               r;
        int               idx;
        int               cnt;
        int               sz;
        sz   = tracker.mirror_size;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        idx  = $urandom_range(0, FIELD_MAX);
        cnt  = $urandom_range(0, FIELD_MAX);
        if (pick < 10)
        begin
            code = bre_pkg::CMD_RESIZE;
            if (r < 70)
                cnt = $urandom_range(0, 300);
            else if (r < 92)
                cnt = $urandom_range(0, MAX_BITS);
        end
        else if (pick < 12)
            code = bre_pkg::CMD_CLEAR;
        else if (pick < 14)
            code = CMD_W'($urandom_range(int'(bre_pkg::CMD_CLEAR) + 1, CMD_LAST_CODE));
        else if (pick < 50)
        begin
            code = CMD_W'($urandom_range(bre_pkg::CMD_GET, bre_pkg::CMD_WRITE));
            idx  = pick_index(sz);
        end
        else if (pick < 85)
        begin
            code = CMD_W'($urandom_range(bre_pkg::CMD_SETRANGE, bre_pkg::CMD_TOGRANGE));
            idx  = pick_index(sz);
            if (r < 60)
                cnt = $urandom_range(0, 70);
            else if (r < 70)
                cnt = 0;
        end
        else
            code = CMD_W'($urandom_range(bre_pkg::CMD_SETALL, bre_pkg::CMD_TOGALL));
        drive_cmd(code, idx, cnt, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        tracker          = new();
        rst_n            = 1'b0;
        cmd_gap_pct      = 21;
        rsp_stall_pct    = 49;
        cmd_if.valid     <= 1'b0;
        cmd_if.command   <= bre_pkg::CMD_GET;
        cmd_if.bit_index <= '0;
        cmd_if.bit_count <= '0;
        cmd_if.bit_value <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        drive_cmd(bre_pkg::CMD_GET, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, 130, 1'b0);
        drive_cmd(bre_pkg::CMD_SET, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_SET, 129, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_TOG, 129, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_WRITE, 64, 0, 1'b1);
        drive_cmd(bre_pkg::CMD_WRITE, 64, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_CLR, 0, 0, 1'b1);
        drive_cmd(bre_pkg::CMD_GET, 130, 0, 1'b1);
        drive_cmd(bre_pkg::CMD_SET, FIELD_MAX, FIELD_MAX, 1'b1);
        drive_cmd(bre_pkg::CMD_SETRANGE, 60, FIELD_MAX, 1'b0);
        drive_cmd(bre_pkg::CMD_CLRRANGE, 100, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_TOGRANGE, 0, 64, 1'b0);
        drive_cmd(bre_pkg::CMD_SETRANGE, 130, 5, 1'b0);
        drive_cmd(bre_pkg::CMD_TOGALL, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_CLRALL, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_SETALL, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, 128, 1'b0);
        drive_cmd(bre_pkg::CMD_SETALL, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, 200, 1'b0);
        drive_cmd(bre_pkg::CMD_GET, 150, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, FIELD_MAX, 1'b0);
        drive_cmd(bre_pkg::CMD_SETALL, 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_TOGRANGE, 4000, FIELD_MAX, 1'b0);
        drive_cmd(bre_pkg::CMD_GET, MAX_BITS - 1, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, 0, 1'b0);
        for (int c = int'(bre_pkg::CMD_CLEAR) + 1; c <= CMD_LAST_CODE; c++)
            drive_cmd(CMD_W'(c), 0, 0, 1'b0);
        drive_cmd(bre_pkg::CMD_RESIZE, 0, 70, 1'b0);
        drive_cmd(bre_pkg::CMD_CLEAR, 0, 0, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            // drain fully before each new idling pattern
            hold_until_drained();
            cmd_gap_pct   = (phase == 0) ? 21 : (phase == 1) ? 49 : 0;
            rsp_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 21 : 0;
            for (int n = 0; n < RANDOM_ITEMS; n++)
                random_command();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.expected_rsps.size() != 0)
            tracker.report("beats never returned", 0, tracker.expected_rsps.size());
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
